FILE: sv/ecv_pkg.sv
`timescale 1ns / 1ps

package ecv_pkg;

  localparam int ECV_STAGES = 10;

  typedef struct packed {
    logic [ECV_STAGES-1:0] en;
    logic [ECV_STAGES-1:0] vld;
  } pipe_ctl_t;

  localparam logic signed [11:0] OFFSET_MAX = 12'sd1439;
  localparam logic signed [11:0] OFFSET_MIN = -12'sd1439;

  // 200000 days of seconds, keeps the biased local time positive
  localparam logic [35:0] DAY_BIAS_SEC = 36'd17280000000;

  localparam logic [29:0] M675  = 30'd814453057;
  localparam logic [36:0] M1460 = 37'd367720;
  localparam logic [36:0] M365  = 37'd367720;
  localparam logic [34:0] M3600 = 35'd149131;
  localparam logic [24:0] M60   = 25'd4370;

  localparam logic [19:0] DQ_LO      = 20'd160000;
  localparam logic [19:0] DQ_HI      = 20'd260000;
  localparam logic [19:0] Z_SHIFT    = 20'd519468;
  localparam logic [19:0] ERA4_START = 20'd584388;
  localparam logic [19:0] ERA5_START = 20'd730485;

  localparam logic [11:0] YEAR_MIN = 12'd1900;
  localparam logic [11:0] YEAR_MAX = 12'd2099;

  localparam logic [8:0] MON_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

endpackage

FILE: sv/ecv_if.sv
`timescale 1ns / 1ps

interface ecv_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] ts_sec;

  modport source (output valid, output ts_sec, input ready);
  modport sink (input valid, input ts_sec, output ready);
endinterface

interface ecv_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  modport source (output valid, output status, output year, output month, output day,
                  output hour, output minute, output second, output weekday,
                  input ready);
  modport sink (input valid, input status, input year, input month, input day,
                input hour, input minute, input second, input weekday,
                output ready);
endinterface

FILE: sv/epoch_seconds_to_civil_time.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// in_ch     in   valid / ready      ts_sec [63:0] signed
// out_ch    out  valid / ready      status, year, month, day, hour, minute, second, weekday
// cfg       in   cfg_we             cfg_wdata [11:0] signed, local offset in minutes
//
// one beat per cycle in and out while out_ch is not stalled; ten register stages from accept to out_ch.valid
// the depth is set by the constant reciprocal multiplies and the corrections after them
// synchronous active-low reset empties the pipeline and sets the offset to zero
// a stalled out_ch holds its beat; empty stages still take new beats behind it

module epoch_seconds_to_civil_time (
  input  logic              clk,
  input  logic              rst_n,
  ecv_in_if.sink            in_ch,
  ecv_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic signed [11:0] cfg_wdata
);
  import ecv_pkg::*;

  pipe_ctl_t ctl;
  logic      in_rdy;

  ecv_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_rdy),
    .ctl       (ctl)
  );

  // offset register, kept as biased seconds
  logic signed [11:0] cfg_sat;
  logic signed [17:0] off_sec;
  logic [35:0]        off_bias_r;
  logic [35:0]        off_bias_nxt;

  always_comb begin
    if (cfg_wdata > OFFSET_MAX) begin
      cfg_sat = OFFSET_MAX;
    end else if (cfg_wdata < OFFSET_MIN) begin
      cfg_sat = OFFSET_MIN;
    end else begin
      cfg_sat = cfg_wdata;
    end
    off_sec      = $signed({{6{cfg_sat[11]}}, cfg_sat}) * $signed(18'sd60);
    off_bias_nxt = DAY_BIAS_SEC + {{18{off_sec[17]}}, off_sec};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_bias_r <= DAY_BIAS_SEC;
    end else if (cfg_we) begin
      off_bias_r <= off_bias_nxt;
    end
  end

  // stage 1: range check and biased local seconds
  logic [35:0] s1_w_nxt;
  logic        s1_oor_nxt;
  logic [35:0] s1_w_r;
  logic        s1_oor_r;

  always_comb begin
    s1_w_nxt   = {in_ch.ts_sec[34], in_ch.ts_sec[34:0]} + off_bias_r;
    s1_oor_nxt = !((&in_ch.ts_sec[63:34]) || !(|in_ch.ts_sec[63:34]));
  end

  // stage 2: day estimate
  logic [58:0] s2_prod;
  logic [19:0] s2_est_r;
  logic [28:0] s2_q0_r;
  logic [6:0]  s2_lo_r;
  logic        s2_oor_r;

  assign s2_prod = 59'(s1_w_r[35:7]) * 59'(M675);

  // stage 3: back-multiply
  logic [29:0] s3_p_nxt;
  logic [29:0] s3_p_r;
  logic [19:0] s3_est_r;
  logic [28:0] s3_q0_r;
  logic [6:0]  s3_lo_r;
  logic        s3_oor_r;

  assign s3_p_nxt = 30'(s2_est_r) * 30'd675;

  // stage 4: correct day and second of day
  logic [28:0] s4_diff;
  logic [10:0] s4_rem;
  logic [10:0] s4_sub;
  logic        s4_fix;
  logic [19:0] s4_dq_nxt;
  logic [16:0] s4_sod_nxt;
  logic [19:0] s4_dq_r;
  logic [16:0] s4_sod_r;
  logic        s4_oor_r;

  always_comb begin
    s4_diff    = s3_q0_r - s3_p_r[28:0];
    s4_rem     = s4_diff[10:0];
    s4_sub     = s4_rem - 11'd675;
    s4_fix     = s4_rem >= 11'd675;
    s4_dq_nxt  = s3_est_r + 20'(s4_fix);
    s4_sod_nxt = {(s4_fix ? s4_sub[9:0] : s4_rem[9:0]), s3_lo_r};
  end

  // stage 5: window, era and day of era
  logic [19:0] s5_z;
  logic [19:0] s5_doe_full;
  logic        s5_era5_nxt;
  logic        s5_err_nxt;
  logic [17:0] s5_doe_r;
  logic        s5_era5_r;
  logic        s5_err_r;
  logic [16:0] s5_sod_r;

  always_comb begin
    s5_z        = s4_dq_r + Z_SHIFT;
    s5_era5_nxt = s5_z >= ERA5_START;
    s5_doe_full = s5_z - (s5_era5_nxt ? ERA5_START : ERA4_START);
    s5_err_nxt  = s4_oor_r || (s4_dq_r < DQ_LO) || (s4_dq_r > DQ_HI);
  end

  // stage 6: leap corrections, hour, octal digit sum for weekday
  logic [36:0] s6_pa;
  logic [34:0] s6_ph;
  logic [2:0]  s6_b_nxt;
  logic [17:0] s6_d3;
  logic [5:0]  s6_osum_nxt;
  logic [6:0]  s6_a_r;
  logic [2:0]  s6_b_r;
  logic        s6_c_r;
  logic [17:0] s6_doe_r;
  logic        s6_era5_r;
  logic        s6_err_r;
  logic [16:0] s6_sod_r;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_osum_r;

  always_comb begin
    s6_pa    = 37'(s5_doe_r) * M1460;
    s6_ph    = 35'(s5_sod_r) * M3600;
    s6_b_nxt = 3'(s5_doe_r >= 18'd36524) + 3'(s5_doe_r >= 18'd73048)
             + 3'(s5_doe_r >= 18'd109572) + 3'(s5_doe_r >= 18'd146096);
    s6_d3       = s5_doe_r + 18'd3;
    s6_osum_nxt = '0;
    for (int i = 0; i < 6; i++) begin
      s6_osum_nxt = s6_osum_nxt + 6'(s6_d3[3*i +: 3]);
    end
  end

  // stage 7: year numerator, minute remainder, weekday fold
  logic [17:0] s7_n_nxt;
  logic [16:0] s7_hm;
  logic [16:0] s7_remw;
  logic [3:0]  s7_f;
  logic [2:0]  s7_wd_nxt;
  logic [17:0] s7_n_r;
  logic [17:0] s7_doe_r;
  logic        s7_era5_r;
  logic        s7_err_r;
  logic [11:0] s7_rem_r;
  logic [4:0]  s7_hour_r;
  logic [2:0]  s7_wd_r;

  always_comb begin
    s7_n_nxt = s6_doe_r - 18'(s6_a_r) + 18'(s6_b_r) - 18'(s6_c_r);
    s7_hm    = 17'(s6_hour_r) * 17'd3600;
    s7_remw  = s6_sod_r - s7_hm;
    s7_f     = 4'(s6_osum_r[5:3]) + 4'(s6_osum_r[2:0]);
    if (s7_f >= 4'd14) begin
      s7_wd_nxt = 3'(s7_f - 4'd14);
    end else if (s7_f >= 4'd7) begin
      s7_wd_nxt = 3'(s7_f - 4'd7);
    end else begin
      s7_wd_nxt = s7_f[2:0];
    end
  end

  // stage 8: year of era, minute
  logic [36:0] s8_pn;
  logic [24:0] s8_pm;
  logic [8:0]  s8_yoe_r;
  logic [17:0] s8_doe_r;
  logic        s8_era5_r;
  logic        s8_err_r;
  logic [11:0] s8_rem_r;
  logic [5:0]  s8_min_r;
  logic [4:0]  s8_hour_r;
  logic [2:0]  s8_wd_r;

  always_comb begin
    s8_pn = 37'(s7_n_r) * M365;
    s8_pm = 25'(s7_rem_r) * M60;
  end

  // stage 9: day of year, second
  logic [1:0]  s9_yc;
  logic [17:0] s9_ty;
  logic [17:0] s9_doyw;
  logic [11:0] s9_sm;
  logic [11:0] s9_secw;
  logic [8:0]  s9_doy_r;
  logic [8:0]  s9_yoe_r;
  logic        s9_era5_r;
  logic        s9_err_r;
  logic [5:0]  s9_min_r;
  logic [5:0]  s9_sec_r;
  logic [4:0]  s9_hour_r;
  logic [2:0]  s9_wd_r;

  always_comb begin
    s9_yc   = 2'(s8_yoe_r >= 9'd100) + 2'(s8_yoe_r >= 9'd200) + 2'(s8_yoe_r >= 9'd300);
    s9_ty   = 18'(s8_yoe_r) * 18'd365 + 18'(s8_yoe_r[8:2]) - 18'(s9_yc);
    s9_doyw = s8_doe_r - s9_ty;
    s9_sm   = 12'(s8_min_r) * 12'd60;
    s9_secw = s8_rem_r - s9_sm;
  end

  // stage 10: month, day, year, range check, output register
  logic [3:0]  s10_mp;
  logic [8:0]  s10_dayw;
  logic [3:0]  s10_month;
  logic [11:0] s10_year;
  logic        s10_err;
  logic        out_status_r;
  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_min_r;
  logic [5:0]  out_sec_r;
  logic [2:0]  out_wd_r;

  always_comb begin
    s10_mp = '0;
    for (int k = 1; k < 12; k++) begin
      if (s9_doy_r >= MON_START[k]) begin
        s10_mp = 4'(k);
      end
    end
    s10_dayw  = s9_doy_r - MON_START[s10_mp] + 9'd1;
    s10_month = (s10_mp < 4'd10) ? s10_mp + 4'd3 : s10_mp - 4'd9;
    s10_year  = 12'(s9_yoe_r) + (s9_era5_r ? 12'd2000 : 12'd1600) + 12'(s10_mp >= 4'd10);
    s10_err   = s9_err_r || (s10_year < YEAR_MIN) || (s10_year > YEAR_MAX);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_w_r   <= s1_w_nxt;
      s1_oor_r <= s1_oor_nxt;
    end
    if (ctl.en[1]) begin
      s2_est_r <= s2_prod[58:39];
      s2_q0_r  <= s1_w_r[35:7];
      s2_lo_r  <= s1_w_r[6:0];
      s2_oor_r <= s1_oor_r;
    end
    if (ctl.en[2]) begin
      s3_p_r   <= s3_p_nxt;
      s3_est_r <= s2_est_r;
      s3_q0_r  <= s2_q0_r;
      s3_lo_r  <= s2_lo_r;
      s3_oor_r <= s2_oor_r;
    end
    if (ctl.en[3]) begin
      s4_dq_r  <= s4_dq_nxt;
      s4_sod_r <= s4_sod_nxt;
      s4_oor_r <= s3_oor_r;
    end
    if (ctl.en[4]) begin
      s5_doe_r  <= s5_doe_full[17:0];
      s5_era5_r <= s5_era5_nxt;
      s5_err_r  <= s5_err_nxt;
      s5_sod_r  <= s4_sod_r;
    end
    if (ctl.en[5]) begin
      s6_a_r    <= s6_pa[35:29];
      s6_b_r    <= s6_b_nxt;
      s6_c_r    <= s5_doe_r == 18'd146096;
      s6_doe_r  <= s5_doe_r;
      s6_era5_r <= s5_era5_r;
      s6_err_r  <= s5_err_r;
      s6_sod_r  <= s5_sod_r;
      s6_hour_r <= s6_ph[33:29];
      s6_osum_r <= s6_osum_nxt;
    end
    if (ctl.en[6]) begin
      s7_n_r    <= s7_n_nxt;
      s7_doe_r  <= s6_doe_r;
      s7_era5_r <= s6_era5_r;
      s7_err_r  <= s6_err_r;
      s7_rem_r  <= s7_remw[11:0];
      s7_hour_r <= s6_hour_r;
      s7_wd_r   <= s7_wd_nxt;
    end
    if (ctl.en[7]) begin
      s8_yoe_r  <= s8_pn[35:27];
      s8_doe_r  <= s7_doe_r;
      s8_era5_r <= s7_era5_r;
      s8_err_r  <= s7_err_r;
      s8_rem_r  <= s7_rem_r;
      s8_min_r  <= s8_pm[23:18];
      s8_hour_r <= s7_hour_r;
      s8_wd_r   <= s7_wd_r;
    end
    if (ctl.en[8]) begin
      s9_doy_r  <= s9_doyw[8:0];
      s9_yoe_r  <= s8_yoe_r;
      s9_era5_r <= s8_era5_r;
      s9_err_r  <= s8_err_r;
      s9_min_r  <= s8_min_r;
      s9_sec_r  <= s9_secw[5:0];
      s9_hour_r <= s8_hour_r;
      s9_wd_r   <= s8_wd_r;
    end
    if (ctl.en[9]) begin
      out_status_r <= s10_err;
      out_year_r   <= s10_err ? '0 : s10_year;
      out_month_r  <= s10_err ? '0 : s10_month;
      out_day_r    <= s10_err ? '0 : s10_dayw[4:0];
      out_hour_r   <= s10_err ? '0 : s9_hour_r;
      out_min_r    <= s10_err ? '0 : s9_min_r;
      out_sec_r    <= s10_err ? '0 : s9_sec_r;
      out_wd_r     <= s10_err ? '0 : s9_wd_r;
    end
  end

  assign in_ch.ready    = in_rdy;
  assign out_ch.valid   = ctl.vld[ECV_STAGES-1];
  assign out_ch.status  = out_status_r;
  assign out_ch.year    = out_year_r;
  assign out_ch.month   = out_month_r;
  assign out_ch.day     = out_day_r;
  assign out_ch.hour    = out_hour_r;
  assign out_ch.minute  = out_min_r;
  assign out_ch.second  = out_sec_r;
  assign out_ch.weekday = out_wd_r;

endmodule

FILE: sv/ecv_pipe_ctl.sv
`timescale 1ns / 1ps

module ecv_pipe_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output ecv_pkg::pipe_ctl_t ctl
);
  import ecv_pkg::*;

  logic [ECV_STAGES-1:0] vld_r;
  logic [ECV_STAGES-1:0] vld_nxt;
  logic [ECV_STAGES-1:0] rdy;

  // a stage loads when it is empty or its beat moves on
  always_comb begin
    rdy[ECV_STAGES-1] = !vld_r[ECV_STAGES-1] || out_ready;
    for (int k = ECV_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < ECV_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = rdy[0];
  assign ctl.en   = rdy;
  assign ctl.vld  = vld_r;

endmodule

FILE: sv/ecv_checker.sv
`timescale 1ns / 1ps

module ecv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [2:0]  weekday
);
  import ecv_pkg::*;

  logic [41:0] beat;

  assign beat = {status, year, month, day, hour, minute, second, weekday};

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(beat))
    else $error("stalled beat changed");

  // error beats carry zeros
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> (beat[40:0] == '0))
    else $error("error beat not zero");

  // good beats are a real local time
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !status |->
      year >= YEAR_MIN && year <= YEAR_MAX && month >= 4'd1 && month <= 4'd12 &&
      day >= 5'd1 && day <= 5'd31 && hour <= 5'd23 && minute <= 6'd59 &&
      second <= 6'd59 && weekday <= 3'd6)
    else $error("date field out of range");

endmodule

bind epoch_seconds_to_civil_time ecv_checker u_ecv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .year      (out_ch.year),
  .month     (out_ch.month),
  .day       (out_ch.day),
  .hour      (out_ch.hour),
  .minute    (out_ch.minute),
  .second    (out_ch.second),
  .weekday   (out_ch.weekday)
);

FILE: verif/tb_epoch_seconds_to_civil_time.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_civil_time;

  localparam longint SEC_PER_DAY  = 86400;
  localparam longint DAY_SHIFT    = 719468;
  localparam longint ERA_DAYS     = 146097;
  localparam longint DAY_LO_LIMIT = -40000;
  localparam longint DAY_HI_LIMIT = 60000;
  localparam longint YEAR_LO_TS   = -64'sd2208988800;
  localparam longint YEAR_HI_TS   = 64'sd4102444800;
  localparam longint WIN_LO_TS    = -64'sd3456000000;
  localparam longint WIN_HI_TS    = 64'sd5184086400;
  localparam int     HOLD_CYCLES  = 60;
  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_BEATS  = 165;
  localparam logic   STATUS_OK    = 1'b0;
  localparam logic   STATUS_RANGE = 1'b1;

  typedef struct {
    logic        status;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } civil_t;

  class civil_checker;
    longint offset_min;
    civil_t pending_civil[$];
    int     fail_count;

    function new();
      offset_min = 0;
      fail_count = 0;
    endfunction

    function void set_offset(logic signed [11:0] w);
      if (w > ecv_pkg::OFFSET_MAX) offset_min = ecv_pkg::OFFSET_MAX;
      else if (w < ecv_pkg::OFFSET_MIN) offset_min = ecv_pkg::OFFSET_MIN;
      else offset_min = w;
    endfunction

    function civil_t civil_from_unix(longint u);
      civil_t r;
      longint days, sod, z, era, yr, wd, doe, yoe, doy, mp, mon, dd;
      r = '{STATUS_RANGE, 0, 0, 0, 0, 0, 0, 0};
      days = u / SEC_PER_DAY;
      sod = u % SEC_PER_DAY;
      if (sod < 0) begin
        sod += SEC_PER_DAY;
        days -= 1;
      end
      sod += offset_min * 60;
      if (sod < 0) begin
        sod += SEC_PER_DAY;
        days -= 1;
      end else if (sod >= SEC_PER_DAY) begin
        sod -= SEC_PER_DAY;
        days += 1;
      end
      if (days < DAY_LO_LIMIT || days > DAY_HI_LIMIT) return r;
      z = days + DAY_SHIFT;
      era = (z >= 0 ? z : z - (ERA_DAYS - 1)) / ERA_DAYS;
      doe = z - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      dd = doy - (153 * mp + 2) / 5 + 1;
      mon = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) yr += 1;
      if (yr < ecv_pkg::YEAR_MIN || yr > ecv_pkg::YEAR_MAX) return r;
      wd = (days + 4) % 7;
      if (wd < 0) wd += 7;
      r.status  = STATUS_OK;
      r.year    = yr[11:0];
      r.month   = mon[3:0];
      r.day     = dd[4:0];
      r.hour    = 5'(sod / 3600);
      r.minute  = 6'((sod % 3600) / 60);
      r.second  = 6'(sod % 60);
      r.weekday = wd[2:0];
      return r;
    endfunction

    function void note_input(longint u);
      pending_civil.push_back(civil_from_unix(u));
    endfunction

    function void cmp(string what, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(civil_t got);
      civil_t want;
      if (pending_civil.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none, actual %0d-%0d-%0d",
                 $time, got.year, got.month, got.day);
        fail_count++;
        return;
      end
      want = pending_civil.pop_front();
      cmp("status", 12'(want.status), 12'(got.status));
      cmp("year", want.year, got.year);
      cmp("month", 12'(want.month), 12'(got.month));
      cmp("day", 12'(want.day), 12'(got.day));
      cmp("hour", 12'(want.hour), 12'(got.hour));
      cmp("minute", 12'(want.minute), 12'(got.minute));
      cmp("second", 12'(want.second), 12'(got.second));
      cmp("weekday", 12'(want.weekday), 12'(got.weekday));
    endfunction

    function int pending_count();
      return pending_civil.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic signed [11:0] cfg_wdata;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  civil_checker sb = new();

  ecv_in_if  in_ch ();
  ecv_out_if out_ch ();

  epoch_seconds_to_civil_time i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint pick_timestamp();
    longint days, sod, u;
    int sel;
    sel = $urandom_range(0, 9);
    sod = $urandom_range(0, 86399);
    case (sel)
      0: begin
        u = {$urandom, $urandom};
      end
      1: begin
        u = ($urandom_range(0, 1) ? YEAR_HI_TS : YEAR_LO_TS)
            + longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
      end
      2: begin
        u = ($urandom_range(0, 1) ? WIN_HI_TS : WIN_LO_TS)
            + longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
      end
      3: begin
        u = longint'($urandom_range(0, 200000)) - 100000;
      end
      default: begin
        days = longint'($urandom_range(0, 73069)) - 25577;
        // bias towards the ends of the day so the offset carries across midnight
        if ($urandom_range(0, 3) == 0)
          sod = $urandom_range(0, 1) ? $urandom_range(0, 1500) : $urandom_range(84900, 86399);
        u = days * SEC_PER_DAY + sod;
      end
    endcase
    return u;
  endfunction

  task automatic write_offset(logic [11:0] w);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_offset(w);
  endtask

  task automatic send_timestamp(longint u);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.ts_sec = u;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(u);
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.ts_sec = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
  end

  // receiver side, with one long hold to back the pipeline up
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result('{out_ch.status, out_ch.year, out_ch.month, out_ch.day,
                        out_ch.hour, out_ch.minute, out_ch.second, out_ch.weekday});
  end

  initial begin : stim
    longint corner_ts[] = '{
      64'sd0, -64'sd1, 64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
      64'sd86399, 64'sd86400, -64'sd86400,
      -64'sd2208988800, -64'sd2208988801, 64'sd4102444799, 64'sd4102444800,
      64'sd951782400, 64'sd951868800, -64'sd2203891200, -64'sd2203977600,
      64'sd2147483647, 64'sd2147483648, 64'sd4294967295,
      -64'sd3456000000, -64'sd3456000001, 64'sd5184086399, 64'sd5184086400,
      64'sd1234567890
    };
    logic [11:0] phase_offset [NUM_PHASES];
    int beats;
    phase_offset = '{12'h000, 12'h59F, 12'hA61, 12'h7FF, 12'h800, 12'h000, 12'h000, 12'h000};
    phase_offset[5] = 12'($urandom_range(0, 4095));
    phase_offset[6] = 12'(int'($urandom_range(0, 2878)) - 1439);
    wait (rst_n === 1'b1);
    for (int p = 0; p < NUM_PHASES; p++) begin
      while (sb.pending_count() != 0) @(posedge clk);
      write_offset(phase_offset[p]);
      beats = PHASE_BEATS;
      if (p == 0) begin
        foreach (corner_ts[i]) send_timestamp(corner_ts[i]);
        beats = 100;
      end
      if (p == 2) hold_req = 1'b1;
      // last phase runs flat out on both sides
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      repeat (beats) send_timestamp(pick_timestamp());
      in_ch.valid = 1'b0;
    end
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
